/* sv/smp_pkg.sv */
// Shared types and constants of the SHA message padder.
`timescale 1ns / 1ps
package smp_pkg;

	// Block buffer geometry: up to 128 bytes kept as 32 words of 4 bytes
	localparam int unsigned RAM_WORDS  = 32;
	localparam int unsigned RAM_AW     = 5;
	localparam int unsigned LEN_BITS   = 128;

	// Input item kinds
	localparam logic FUNC_APPEND = 1'b0;
	localparam logic FUNC_FINISH = 1'b1;

	// Hash modes below this code use 64-byte blocks and 8 length bytes
	localparam logic [1:0] MODE_SHA384 = 2'd2;

	localparam logic [7:0] PAD_MARK  = 8'h80;
	localparam logic [7:0] SMALL_BLK = 8'd64;

	// Register indexes on the configuration port
	localparam logic REG_HASH_MODE = 1'b0;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} seq_state_t;

	// Per-block control handed to the word formatter
	typedef struct packed {
		logic       pad;       // final padded block(s)
		logic       lenb16;    // 16 length bytes instead of 8
		logic [6:0] fill;      // first byte position not taken from the buffer
		logic [7:0] total_m1;  // last byte position of the emitted run
	} pad_ctl_t;

endpackage

/* sv/sha_message_padder_core.sv */
// Top level of the SHA message padder: sequencer, counters and output register.
`timescale 1ns / 1ps
// Message padder in front of a SHA-1/224/256/384/512 compression engine.
// Slave stream: one item per transaction; tuser 0 appends the byte in tdata,
// tuser 1 finishes the message and emits the padded final block(s).
// Master stream: one 32-bit block word per transaction, lowest-addressed
// byte in bits 7:0; tuser flags continue_round, block_end and message_end,
// tlast marks the last word caused by one input item.
// APB port: hash_mode at address 0 (0 sha1, 1 sha256, 2 sha384, 3 sha512);
// write it only while the block is idle.
// An append that does not complete a block leaves s_tready high. A byte that
// completes a block, and a finish item, hold s_tready low while the block
// words are read out of the buffer RAM at one word per cycle when the receiver
// does not stall: bsz/4 words (or 2*bsz/4 for a two-block finish). The first
// word passes the RAM read stage and the output register before m_tvalid.
// When the receiver stalls, the read pipeline holds and the next buffer read
// is issued only when the output register frees up; no word is dropped.
// Reset clears the counters, the fill position and the sequencer at once; the
// buffer RAM needs no clearing since padding never reads unwritten bytes.
module sha_message_padder_core #(
	parameter int unsigned MAX_BLOCK_BYTES = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] func
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] data_word
	output logic [2:0]  m_tuser,   // [0] continue_round, [1] block_end, [2] message_end
	output logic        m_tlast    // last
);
	import smp_pkg::*;

	// large-block size, clamped and rounded to whole words
	localparam int unsigned BLK_CLAMP = (MAX_BLOCK_BYTES < 64) ? 64 :
		((MAX_BLOCK_BYTES > 128) ? 128 : MAX_BLOCK_BYTES);
	localparam int unsigned BLK_BIG = BLK_CLAMP - (BLK_CLAMP % 4);

	logic [1:0]  hash_mode;

	seq_state_t  state_q;
	logic [6:0]  fill_q;
	logic [63:0] cnt_lo_q;
	logic [63:0] cnt_hi_q;
	logic        seen_q;

	// per-run registers
	pad_ctl_t    ctl_q;
	logic        cont0_q;
	logic [4:0]  bw_last_q;
	logic [5:0]  nw_last_q;
	logic [5:0]  rd_w_q;
	logic        issue_done_q;
	logic [LEN_BITS-1:0] len_q;

	// read pipeline
	logic        valid_s1;
	logic [5:0]  w_s1;

	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;
	logic [2:0]  m_tuser_q;
	logic        m_tlast_q;

	logic        in_acc;
	logic [7:0]  bsz;
	logic [7:0]  f_eff;
	logic [7:0]  f_next;
	logic [7:0]  room;
	logic        lenb16;
	logic [8:0]  total;
	logic [4:0]  bw_last;
	logic        rd_en;
	logic        s1_move;
	logic [31:0] ram_rdata;
	logic [31:0] fmt_word;
	logic        w_cont;
	logic        w_bend;
	logic        w_last;

	smp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.hash_mode (hash_mode)
	);

	// block geometry for the current mode
	always_comb begin
		bsz     = (hash_mode < MODE_SHA384) ? SMALL_BLK : BLK_BIG[7:0];
		lenb16  = (hash_mode >= MODE_SHA384);
		f_eff   = ({1'b0, fill_q} >= bsz) ? ({1'b0, fill_q} - bsz) : {1'b0, fill_q};
		f_next  = f_eff + 8'd1;
		room    = bsz - f_eff;
		total   = (room >= (lenb16 ? 8'd17 : 8'd9)) ? {1'b0, bsz} : {bsz, 1'b0};
		bw_last = 5'(bsz[7:2] - 6'd1);
	end

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	// read pipeline handshake
	assign s1_move = valid_s1 && (!m_tvalid_q || m_tready);
	assign rd_en   = (state_q == ST_EMIT) && !issue_done_q && (!valid_s1 || s1_move);

	smp_ram u_ram (
		.clk   (clk),
		.we    (in_acc && (s_tuser == FUNC_APPEND)),
		.waddr (f_eff[6:2]),
		.wlane (f_eff[1:0]),
		.wbyte (s_tdata),
		.re    (rd_en),
		.raddr (rd_w_q[4:0]),
		.rdata (ram_rdata)
	);

	smp_fmt u_fmt (
		.ctl       (ctl_q),
		.word_idx  (w_s1),
		.ram_word  (ram_rdata),
		.len_bits  (len_q),
		.data_word (fmt_word)
	);

	// sequencer, counters and run setup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fill_q       <= 7'd0;
			cnt_lo_q     <= 64'd0;
			cnt_hi_q     <= 64'd0;
			seen_q       <= 1'b0;
			rd_w_q       <= 6'd0;
			issue_done_q <= 1'b0;
			valid_s1     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						rd_w_q       <= 6'd0;
						issue_done_q <= 1'b0;
						if (s_tuser == FUNC_APPEND) begin
							cnt_lo_q <= cnt_lo_q + 64'd1;
							if (&cnt_lo_q) begin
								cnt_hi_q <= cnt_hi_q + 64'd1;
							end
							if (f_next == bsz) begin
								fill_q  <= 7'd0;
								seen_q  <= 1'b1;
								state_q <= ST_EMIT;
							end else begin
								fill_q <= f_next[6:0];
							end
						end else begin
							fill_q   <= 7'd0;
							cnt_lo_q <= 64'd0;
							cnt_hi_q <= 64'd0;
							seen_q   <= 1'b0;
							state_q  <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (rd_en) begin
						rd_w_q <= rd_w_q + 6'd1;
						if (rd_w_q == nw_last_q) begin
							issue_done_q <= 1'b1;
						end
					end
					if (issue_done_q && s1_move) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (rd_en) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// run parameters latched on every accepted input item
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cont0_q        <= seen_q;
			bw_last_q      <= bw_last;
			ctl_q.lenb16   <= lenb16;
			ctl_q.fill     <= f_eff[6:0];
			if (s_tuser == FUNC_APPEND) begin
				ctl_q.pad      <= 1'b0;
				ctl_q.total_m1 <= bsz - 8'd1;
				nw_last_q      <= {1'b0, bw_last};
			end else begin
				ctl_q.pad      <= 1'b1;
				ctl_q.total_m1 <= 8'(total - 9'd1);
				nw_last_q      <= 6'(total[8:2] - 7'd1);
				len_q          <= {cnt_hi_q[60:0], cnt_lo_q, 3'b000};
			end
		end
		if (rd_en) begin
			w_s1 <= rd_w_q;
		end
	end

	// word flags
	always_comb begin
		w_cont = (w_s1 <= {1'b0, bw_last_q}) ? cont0_q : 1'b1;
		w_bend = (w_s1 == {1'b0, bw_last_q}) || (w_s1 == {bw_last_q, 1'b1});
		w_last = (w_s1 == nw_last_q);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s1_move) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			m_tdata_q <= fmt_word;
			m_tuser_q <= {ctl_q.pad, w_bend, w_cont};
			m_tlast_q <= w_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

/* sv/smp_cfg.sv */
// APB register file holding the hash mode.
`timescale 1ns / 1ps
module smp_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [1:0]  hash_mode
);
	import smp_pkg::*;

	logic [1:0] mode_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// mode register, written in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 2'd0;
		end else if (wr_en && (paddr[2] == REG_HASH_MODE)) begin
			mode_q <= pwdata[1:0];
		end
	end

	// read back
	always_comb begin
		if (paddr[2] == REG_HASH_MODE) begin
			prdata = {30'd0, mode_q};
		end else begin
			prdata = 32'd0;
		end
	end

	assign hash_mode = mode_q;

endmodule

/* sv/smp_ram.sv */
// Block buffer: 32 words with byte-lane writes and a registered read port.
`timescale 1ns / 1ps
module smp_ram (
	input  logic                      clk,
	input  logic                      we,
	input  logic [smp_pkg::RAM_AW-1:0] waddr,
	input  logic [1:0]                wlane,
	input  logic [7:0]                wbyte,
	input  logic                      re,
	input  logic [smp_pkg::RAM_AW-1:0] raddr,
	output logic [31:0]               rdata
);
	import smp_pkg::*;

	logic [31:0] mem_q [RAM_WORDS];
	logic [31:0] rdata_q;

	// byte write into one lane
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr][{wlane, 3'b000} +: 8] <= wbyte;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/smp_fmt.sv */
// Word formatter: buffer bytes, pad mark, zero fill and big-endian bit length.
`timescale 1ns / 1ps
module smp_fmt (
	input  smp_pkg::pad_ctl_t          ctl,
	input  logic [5:0]                 word_idx,
	input  logic [31:0]                ram_word,
	input  logic [smp_pkg::LEN_BITS-1:0] len_bits,
	output logic [31:0]                data_word
);
	import smp_pkg::*;

	logic [7:0] pos      [4];
	logic [7:0] from_end [4];

	// one byte lane at a time, lanes are independent
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			pos[i]      = {word_idx, 2'(i)};
			from_end[i] = ctl.total_m1 - pos[i];
			if (!ctl.pad || (pos[i] < {1'b0, ctl.fill})) begin
				data_word[i*8 +: 8] = ram_word[i*8 +: 8];
			end else if (pos[i] == {1'b0, ctl.fill}) begin
				data_word[i*8 +: 8] = PAD_MARK;
			end else if (from_end[i] < (ctl.lenb16 ? 8'd16 : 8'd8)) begin
				// distance from the end selects the length byte, LSB last
				data_word[i*8 +: 8] = len_bits[{from_end[i][3:0], 3'b000} +: 8];
			end else begin
				data_word[i*8 +: 8] = 8'd0;
			end
		end
	end

endmodule
